@@ design/prp_pkg.sv @@
`default_nettype none
package prp_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int TRIG_FRAC       = 14;
  localparam int CORDIC_STEPS    = 16;
  localparam int CORDIC_START    = 39797;
  localparam int DIV_CELLS       = 27;

  typedef enum logic [2:0] {
    REG_ANGLE_X = 3'd0,
    REG_ANGLE_Y = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_SCALE_R = 3'd3,
    REG_SIGHT_X = 3'd4,
    REG_SIGHT_Y = 3'd5,
    REG_SIGHT_Z = 3'd6
  } prp_reg_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_LOAD,
    TRIG_RUN,
    TRIG_STORE
  } prp_trig_state_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               frame_end;
  } prp_in_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [7:0]         shade;
    logic               visible;
    logic               div_fault;
    logic               frame_done;
  } prp_out_t;

  // cos/sin per axis, Q3.14
  typedef struct packed {
    logic signed [16:0] cos_x;
    logic signed [16:0] sin_x;
    logic signed [16:0] cos_y;
    logic signed [16:0] sin_y;
    logic signed [16:0] cos_z;
    logic signed [16:0] sin_z;
  } prp_trig_t;

  // one slot of the divider chain: two lanes sharing a divisor
  typedef struct packed {
    logic               valid;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic [7:0]         shade;
    logic               vis;
    logic               fault;
    logic               fe;
    logic               neg_x;
    logic               neg_y;
    logic [16:0]        dmag;
    logic [16:0]        rem_x;
    logic [16:0]        rem_y;
    logic [DIV_CELLS-1:0] nq_x;
    logic [DIV_CELLS-1:0] nq_y;
  } prp_cell_t;

  function automatic logic [13:0] atan_step(input logic [3:0] i);
    case (i)
      4'd0:    atan_step = 14'd8192;
      4'd1:    atan_step = 14'd4836;
      4'd2:    atan_step = 14'd2555;
      4'd3:    atan_step = 14'd1297;
      4'd4:    atan_step = 14'd651;
      4'd5:    atan_step = 14'd326;
      4'd6:    atan_step = 14'd163;
      4'd7:    atan_step = 14'd81;
      4'd8:    atan_step = 14'd41;
      4'd9:    atan_step = 14'd20;
      4'd10:   atan_step = 14'd10;
      4'd11:   atan_step = 14'd5;
      4'd12:   atan_step = 14'd3;
      4'd13:   atan_step = 14'd1;
      4'd14:   atan_step = 14'd1;
      default: atan_step = 14'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ design/point_rotate_project.sv @@
`default_nettype none
// Point rotation and perspective projection. Each item is a Q4.12 point
// that is rotated about X, then Y, then Z by the configured angles and then
// projected to screen pixels as coord*scale_r/(sight_z - z) + sight offset,
// with a grey shade, a visible flag and a division fault flag. One item is
// accepted per clock unless in_ready is low. The path runs through three
// 2-stage rotators, one projection-setup stage, one magnitude stage, a
// chain of 27 divider cells producing one quotient bit each, and the
// output register. Cos and sin come from a shared iterative CORDIC that
// runs load, 16 steps and store per angle: it sweeps all three angles after
// reset and again after every angle write, and in_ready stays low during
// the sweep. Configuration writes are accepted every cycle. A result held
// by out_ready low stalls the chain only when the stage behind the output
// register holds an item.
module point_rotate_project import prp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire prp_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output prp_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0]        angle_x_r, angle_y_r, angle_z_r;
  logic [11:0]        scale_r_r;
  logic signed [15:0] sight_x_r, sight_y_r, sight_z_r;
  logic               cfg_acc, angle_wr;

  prp_trig_t          trig;
  logic               trig_busy;

  logic               en, out_free, in_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign angle_wr  = cfg_acc && (cfg_index inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
      scale_r_r <= 12'd200;
      sight_x_r <= '0;
      sight_y_r <= '0;
      sight_z_r <= 16'sd12288;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_ANGLE_X: angle_x_r <= cfg_data;
        REG_ANGLE_Y: angle_y_r <= cfg_data;
        REG_ANGLE_Z: angle_z_r <= cfg_data;
        REG_SCALE_R: scale_r_r <= cfg_data[11:0];
        REG_SIGHT_X: sight_x_r <= cfg_data;
        REG_SIGHT_Y: sight_y_r <= cfg_data;
        REG_SIGHT_Z: sight_z_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  prp_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (angle_wr),
    .angle_x (angle_x_r),
    .angle_y (angle_y_r),
    .angle_z (angle_z_r),
    .busy    (trig_busy),
    .trig    (trig)
  );

  // flow control: the whole chain advances together unless a finished
  // item waits at the output and another one is right behind it
  prp_cell_t chain [DIV_CELLS+1];
  logic      out_valid_r;
  prp_out_t  out_data_r;

  assign out_free = !out_valid_r || out_ready;
  assign en       = out_free || !chain[DIV_CELLS].valid;
  assign in_ready = en && !trig_busy;
  assign in_acc   = in_valid && in_ready;

  // rotation: X rotates (y,z), Y rotates (x,z), Z rotates (x,y)
  logic signed [15:0] y1, z1, x2, z2, x3, y3;
  logic signed [15:0] xa_r, xb_r, ya_r, yb_r, za_r, zb_r;
  logic [5:0]         v_r, fe_r;

  prp_rot u_rot_x (
    .clk (clk), .en (en),
    .a (in_data.point_y), .b (in_data.point_z),
    .c (trig.cos_x), .s (trig.sin_x),
    .na (y1), .nb (z1)
  );

  prp_rot u_rot_y (
    .clk (clk), .en (en),
    .a (xb_r), .b (z1),
    .c (trig.cos_y), .s (trig.sin_y),
    .na (x2), .nb (z2)
  );

  prp_rot u_rot_z (
    .clk (clk), .en (en),
    .a (x2), .b (yb_r),
    .c (trig.cos_z), .s (trig.sin_z),
    .na (x3), .nb (y3)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_acc};
    end
    if (en) begin
      fe_r <= {fe_r[4:0], in_data.frame_end};
      xa_r <= in_data.point_x;
      xb_r <= xa_r;
      ya_r <= y1;
      yb_r <= ya_r;
      za_r <= z2;
      zb_r <= za_r;
    end
  end

  // projection setup: numerators, depth difference, shade, flags
  localparam logic signed [21:0] SHADE_BIAS = 22'((1 << COORD_FRAC_BITS) - 1);

  logic               p_v_r, p_fe_r, p_vis_r, p_fault_r;
  logic signed [15:0] p_rx_r, p_ry_r, p_rz_r;
  logic signed [27:0] p_nx_r, p_ny_r;
  logic signed [16:0] p_d_r;
  logic [7:0]         p_shade_r;
  logic signed [21:0] z50, zb_sh, sh;
  logic [7:0]         shade_c;
  logic signed [12:0] scale_s;

  assign scale_s = signed'({1'b0, scale_r_r});

  always_comb begin
    z50   = 22'(zb_r) * 22'sd50;
    zb_sh = z50 + (z50[21] ? SHADE_BIAS : 22'sd0);  // truncate toward zero
    sh    = (zb_sh >>> COORD_FRAC_BITS) + 22'sd105;
    if (sh < 22'sd0) begin
      shade_c = 8'd0;
    end else if (sh > 22'sd255) begin
      shade_c = 8'd255;
    end else begin
      shade_c = sh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= v_r[5];
    end
    if (en) begin
      p_fe_r    <= fe_r[5];
      p_rx_r    <= x3;
      p_ry_r    <= y3;
      p_rz_r    <= zb_r;
      p_nx_r    <= 28'(29'(x3) * 29'(scale_s));
      p_ny_r    <= 28'(29'(y3) * 29'(scale_s));
      p_d_r     <= 17'(sight_z_r) - 17'(zb_r);
      p_fault_r <= (sight_z_r == zb_r);
      p_vis_r   <= (zb_r <= sight_z_r);
      p_shade_r <= shade_c;
    end
  end

  // magnitudes and signs for the unsigned divider chain
  prp_cell_t          c0_r, c0_nxt;
  logic signed [27:0] ax, ay;
  logic signed [16:0] ad;

  always_comb begin
    ax = p_nx_r[27] ? -p_nx_r : p_nx_r;
    ay = p_ny_r[27] ? -p_ny_r : p_ny_r;
    ad = p_d_r[16]  ? -p_d_r  : p_d_r;
    c0_nxt = c0_r;
    if (en) begin
      c0_nxt.valid = p_v_r;
      c0_nxt.rx    = p_rx_r;
      c0_nxt.ry    = p_ry_r;
      c0_nxt.rz    = p_rz_r;
      c0_nxt.shade = p_shade_r;
      c0_nxt.vis   = p_vis_r;
      c0_nxt.fault = p_fault_r;
      c0_nxt.fe    = p_fe_r;
      c0_nxt.neg_x = p_nx_r[27] ^ p_d_r[16];
      c0_nxt.neg_y = p_ny_r[27] ^ p_d_r[16];
      c0_nxt.dmag  = ad;
      c0_nxt.rem_x = '0;
      c0_nxt.rem_y = '0;
      c0_nxt.nq_x  = ax[DIV_CELLS-1:0];
      c0_nxt.nq_y  = ay[DIV_CELLS-1:0];
    end
    if (!rst_n) begin
      c0_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    c0_r <= c0_nxt;
  end

  assign chain[0] = c0_r;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    prp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  // sign, offset, saturate; zero the screen on a fault
  prp_cell_t          last;
  logic signed [28:0] qx, qy, sx, sy;
  prp_out_t           res;

  assign last = chain[DIV_CELLS];

  always_comb begin
    qx = signed'({2'b00, last.nq_x});
    qy = signed'({2'b00, last.nq_y});
    if (last.neg_x) begin
      qx = -qx;
    end
    if (last.neg_y) begin
      qy = -qy;
    end
    sx = qx + 29'(sight_x_r);
    sy = qy + 29'(sight_y_r);
    res.rot_x      = last.rx;
    res.rot_y      = last.ry;
    res.rot_z      = last.rz;
    res.screen_x   = last.fault ? 16'sd0 : sat16(40'(sx));
    res.screen_y   = last.fault ? 16'sd0 : sat16(40'(sy));
    res.shade      = last.shade;
    res.visible    = last.vis;
    res.div_fault  = last.fault;
    res.frame_done = last.fe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= last.valid;
    end
    if (out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a fault result never carries a screen position
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_fault |-> out_data.screen_x == 16'sd0 &&
                                        out_data.screen_y == 16'sd0)
    else $error("fault result with nonzero screen position");

  // depth equal to sight counts as visible
  a_fault_vis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_fault |-> out_data.visible)
    else $error("fault result not visible");

  // trig tables are rebuilt after reset before any item enters
  a_reset_sweep: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("item taken before trig sweep after reset");

  // an angle write holds off items until its sweep is done
  a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    angle_wr |=> !in_ready)
    else $error("item taken right after angle write");

endmodule
`default_nettype wire

@@ design/prp_trig.sv @@
`default_nettype none
module prp_trig import prp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] angle_x,
  input  wire logic [15:0] angle_y,
  input  wire logic [15:0] angle_z,
  output logic             busy,
  output prp_trig_t        trig
);

  prp_trig_state_t    state_r, state_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [1:0]         q_r, q_nxt;
  logic signed [18:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [15:0] cz_r, cz_nxt;
  prp_trig_t          trig_r, trig_nxt;
  logic [15:0]        angle_sel;

  always_comb begin
    case (idx_r)
      2'd0:    angle_sel = angle_x;
      2'd1:    angle_sel = angle_y;
      default: angle_sel = angle_z;
    endcase
  end

  always_comb begin
    logic [15:0]        t;
    logic signed [18:0] dx, dy, cr, sr;
    logic signed [15:0] at;
    logic signed [16:0] c, s, co, si;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    q_nxt     = q_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    trig_nxt  = trig_r;
    t  = angle_sel + 16'd8192;
    dx = cy_r >>> step_r;
    dy = cx_r >>> step_r;
    at = signed'({2'b00, atan_step(step_r)});
    cr = cx_r + 19'sd2;
    sr = cy_r + 19'sd2;
    c  = signed'(cr[18:2]);
    s  = signed'(sr[18:2]);
    case (q_r)
      2'd0:    begin co = c;  si = s;  end
      2'd1:    begin co = -s; si = c;  end
      2'd2:    begin co = -c; si = -s; end
      default: begin co = s;  si = -c; end
    endcase
    case (state_r)
      TRIG_LOAD: begin
        q_nxt     = t[15:14];
        cz_nxt    = signed'({2'b00, t[13:0]}) - 16'sd8192;
        cx_nxt    = 19'(CORDIC_START);
        cy_nxt    = '0;
        step_nxt  = '0;
        state_nxt = TRIG_RUN;
      end
      TRIG_RUN: begin
        if (!cz_r[15]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - at;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + at;
        end
        if (step_r == 4'(CORDIC_STEPS - 1)) begin
          state_nxt = TRIG_STORE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      TRIG_STORE: begin
        case (idx_r)
          2'd0:    begin trig_nxt.cos_x = co; trig_nxt.sin_x = si; end
          2'd1:    begin trig_nxt.cos_y = co; trig_nxt.sin_y = si; end
          default: begin trig_nxt.cos_z = co; trig_nxt.sin_z = si; end
        endcase
        if (idx_r == 2'd2) begin
          state_nxt = TRIG_IDLE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = TRIG_LOAD;
        end
      end
      default: ;
    endcase
    // restart the whole sweep on any angle write
    if (start) begin
      state_nxt = TRIG_LOAD;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRIG_LOAD;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    step_r <= step_nxt;
    q_r    <= q_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    trig_r <= trig_nxt;
  end

  assign busy = (state_r != TRIG_IDLE);
  assign trig = trig_r;

endmodule
`default_nettype wire

@@ design/prp_rot.sv @@
`default_nettype none
module prp_rot import prp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  input  wire logic signed [16:0] c,
  input  wire logic signed [16:0] s,
  output logic signed [15:0]      na,
  output logic signed [15:0]      nb
);

  logic signed [32:0] ac_r, bs_r, as_r, bc_r;
  logic signed [15:0] na_r, nb_r;
  logic signed [33:0] sum_a, sum_b;
  logic signed [33:0] half;

  assign half  = 34'sd1 <<< (TRIG_FRAC - 1);
  assign sum_a = 34'(ac_r) - 34'(bs_r) + half;
  assign sum_b = 34'(as_r) + 34'(bc_r) + half;

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r <= 33'(a) * 33'(c);
      bs_r <= 33'(b) * 33'(s);
      as_r <= 33'(a) * 33'(s);
      bc_r <= 33'(b) * 33'(c);
      na_r <= sat16(40'(sum_a >>> TRIG_FRAC));
      nb_r <= sat16(40'(sum_b >>> TRIG_FRAC));
    end
  end

  assign na = na_r;
  assign nb = nb_r;

endmodule
`default_nettype wire

@@ design/prp_div_cell.sv @@
`default_nettype none
module prp_div_cell import prp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire prp_cell_t cell_in,
  output prp_cell_t      cell_out
);

  prp_cell_t   cell_r, cell_nxt;
  logic [17:0] rx2, ry2, dd;
  logic        gex, gey;

  // one restoring quotient bit per lane; hold the slot while stalled
  always_comb begin
    dd  = {1'b0, cell_in.dmag};
    rx2 = {cell_in.rem_x, cell_in.nq_x[DIV_CELLS-1]};
    ry2 = {cell_in.rem_y, cell_in.nq_y[DIV_CELLS-1]};
    gex = (rx2 >= dd);
    gey = (ry2 >= dd);
    cell_nxt = cell_r;
    if (en) begin
      cell_nxt       = cell_in;
      cell_nxt.rem_x = gex ? 17'(rx2 - dd) : rx2[16:0];
      cell_nxt.rem_y = gey ? 17'(ry2 - dd) : ry2[16:0];
      cell_nxt.nq_x  = {cell_in.nq_x[DIV_CELLS-2:0], gex};
      cell_nxt.nq_y  = {cell_in.nq_y[DIV_CELLS-2:0], gey};
    end
    if (!rst_n) begin
      cell_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire
